/* rtl/lpt_pkg.sv */
// shared constants, field widths and control/status types for the prefix trie
package lpt_pkg;

    // default sizing
    localparam int unsigned NODE_COUNT_DEF    = 1024;
    localparam int unsigned ALPHABET_SIZE_DEF = 26;

    // request field widths
    localparam int unsigned OP_W     = 2;
    localparam int unsigned LETTER_W = 5;

    // operation codes (codes 2 and 3 act as a prefix test)
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // take request fields, launch memory reads
        logic exec;     // apply one letter to the walk
        logic init;     // zero the row of the node just allocated
        logic finish;   // close the word, load the result register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic alloc;     // current letter allocates a node
        logic out_free;  // result register can take a new result
    } t_status;

endpackage

/* rtl/lowercase_prefix_trie.sv */
// top level of the lowercase prefix trie: stream ports, sequencer and datapath
// A word enters one letter per request on the slave stream (op on tuser,
// letter on tdata, tlast on the closing end-of-word request, whose letter is
// ignored); only the closing request produces a result on the master stream.
// A letter is taken in the idle state, which launches the synchronous reads of the
// child link, presence row and word mark at the cursor node, and the walk is
// updated in the exec state; a letter that allocates a node also passes the init
// state to zero the new node's presence row and word mark. The end-of-word
// request waits in the finish state while the downstream side holds the previous
// result. After reset the boot state zeroes the root's row before any request.
// Nodes are never freed; when the pool is full an insert reports overflow.
module lowercase_prefix_trie
    import lpt_pkg::*;
#(
    parameter int unsigned NODE_COUNT    = NODE_COUNT_DEF,
    parameter int unsigned ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // request stream
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [7:0]      i_s_tdata,   // [4:0] letter, [7:5] zero fill
    input  logic [OP_W-1:0] i_s_tuser,   // [1:0] op
    input  logic            i_s_tlast,   // end of word
    // result stream
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [7:0]      o_m_tdata    // [0] found, [1] overflow, [7:2] zero fill
);

    t_cmd    w_cmd;
    t_status w_st;
    logic    w_found;
    logic    w_overflow;

    // sequencer
    lpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .i_st       (w_st),
        .o_cmd      (w_cmd),
        .o_s_tready (o_s_tready)
    );

    // tables and walk state
    lpt_dpath #(
        .NODE_COUNT    (NODE_COUNT),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_st        (w_st),
        .i_op        (i_s_tuser),
        .i_letter    (i_s_tdata[LETTER_W-1:0]),
        .i_m_tready  (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_found     (w_found),
        .o_overflow  (w_overflow)
    );

    // result packing
    assign o_m_tdata = {6'd0, w_overflow, w_found};

endmodule

/* rtl/lpt_ctrl.sv */
// sequencer for the prefix trie: request intake, letter step, node init, word close
module lpt_ctrl
    import lpt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    input  logic    i_s_tlast,
    input  t_status i_st,
    output t_cmd    o_cmd,
    output logic    o_s_tready
);

    typedef enum logic [2:0] {
        S_BOOT,
        S_IDLE,
        S_EXEC,
        S_INIT,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;

    // command decode
    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = (r_state == S_IDLE) && r_ready && i_s_tvalid;
        o_cmd.exec    = (r_state == S_EXEC);
        o_cmd.init    = (r_state == S_INIT) || (r_state == S_BOOT);
        o_cmd.finish  = (r_state == S_FINISH) && i_st.out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_BOOT: n_state = S_IDLE;
            S_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = i_s_tlast ? S_FINISH : S_EXEC;
                end
            end
            S_EXEC: n_state = i_st.alloc ? S_INIT : S_IDLE;
            S_INIT: n_state = S_IDLE;
            S_FINISH: begin
                if (i_st.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_BOOT;
        endcase
        n_ready = (n_state == S_IDLE);
    end

    // state and ready register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_BOOT;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_s_tready = r_ready;

endmodule

/* rtl/lpt_dpath.sv */
// trie datapath: node tables, walk cursor, allocation counter and result register
module lpt_dpath
    import lpt_pkg::*;
#(
    parameter int unsigned NODE_COUNT    = NODE_COUNT_DEF,
    parameter int unsigned ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_st,
    input  logic [OP_W-1:0]     i_op,
    input  logic [LETTER_W-1:0] i_letter,
    input  logic                i_m_tready,
    output logic                o_out_valid,
    output logic                o_found,
    output logic                o_overflow
);

    localparam int unsigned NODE_W  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int unsigned CNT_W   = $clog2(NODE_COUNT + 1);
    localparam int unsigned LET_W   = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int unsigned LINK_N  = NODE_COUNT * ALPHABET_SIZE;
    localparam int unsigned LINK_AW = $clog2(LINK_N);

    // node tables
    logic [NODE_W-1:0]        link_mem    [LINK_N];
    logic [ALPHABET_SIZE-1:0] present_mem [NODE_COUNT];
    logic                     mark_mem    [NODE_COUNT];

    // walk state
    logic [OP_W-1:0]          r_op;
    logic [LETTER_W-1:0]      r_letter;
    logic [LINK_AW-1:0]       r_link_addr;
    logic [NODE_W-1:0]        r_cursor;
    logic [NODE_W-1:0]        r_init_node;
    logic [CNT_W-1:0]         r_used;
    logic                     r_missed;
    logic                     r_ovf;
    logic [ALPHABET_SIZE-1:0] r_row;
    logic [NODE_W-1:0]        r_link;
    logic                     r_mark;
    logic                     r_out_valid;
    logic                     r_found;
    logic                     r_out_ovf;

    logic [LINK_AW-1:0]       w_rd_addr;
    logic [LET_W-1:0]         w_idx;
    logic [ALPHABET_SIZE-1:0] w_bit;
    logic                     w_in_range;
    logic                     w_halted;
    logic                     w_present;
    logic                     w_full;
    logic                     w_alloc;
    logic                     w_walked;
    logic                     w_found;
    logic                     w_mark_wr;

    // slot of the child link for the incoming letter
    assign w_rd_addr = LINK_AW'(r_cursor) * LINK_AW'(ALPHABET_SIZE) + LINK_AW'(i_letter);

    // letter step decode
    assign w_idx      = LET_W'(r_letter);
    assign w_bit      = {{(ALPHABET_SIZE-1){1'b0}}, 1'b1} << w_idx;
    assign w_in_range = ({27'd0, r_letter} < 32'(ALPHABET_SIZE));
    assign w_halted   = r_missed || r_ovf;
    assign w_present  = |(r_row & w_bit);
    assign w_full     = (r_used == CNT_W'(NODE_COUNT));
    assign w_alloc    = !w_halted && w_in_range && !w_present && (r_op == OP_INSERT) && !w_full;

    // word close decode
    assign w_walked = !w_halted;
    always_comb begin
        case (r_op)
            OP_INSERT: w_found = 1'b0;
            OP_SEARCH: w_found = w_walked && r_mark;
            default:   w_found = w_walked;
        endcase
    end
    assign w_mark_wr = i_cmd.finish && (r_op == OP_INSERT) && w_walked;

    assign o_st.alloc    = i_cmd.exec && w_alloc;
    assign o_st.out_free = !r_out_valid || i_m_tready;

    // link table: read on request intake, write on allocation
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_link <= link_mem[w_rd_addr];
        end
        if (i_cmd.exec && w_alloc) begin
            link_mem[r_link_addr] <= NODE_W'(r_used);
        end
    end

    // presence table: read on intake, set a bit on allocation, zero a new row
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_row <= present_mem[r_cursor];
        end
        if (i_cmd.exec && w_alloc) begin
            present_mem[r_cursor] <= r_row | w_bit;
        end else if (i_cmd.init) begin
            present_mem[r_init_node] <= '0;
        end
    end

    // word end marks: read on intake, set on insert close, clear for a new node
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mark <= mark_mem[r_cursor];
        end
        if (w_mark_wr) begin
            mark_mem[r_cursor] <= 1'b1;
        end else if (i_cmd.init) begin
            mark_mem[r_init_node] <= 1'b0;
        end
    end

    // request fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op        <= i_op;
            r_letter    <= i_letter;
            r_link_addr <= w_rd_addr;
        end
    end

    // walk control and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_init_node <= '0;
            r_used      <= CNT_W'(1);
            r_missed    <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec && !w_halted) begin
                if (!w_in_range) begin
                    r_missed <= 1'b1;
                end else if (w_present) begin
                    r_cursor <= r_link;
                end else if (r_op != OP_INSERT) begin
                    r_missed <= 1'b1;
                end else if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_cursor    <= NODE_W'(r_used);
                    r_init_node <= NODE_W'(r_used);
                    r_used      <= r_used + CNT_W'(1);
                end
            end
            if (i_cmd.finish) begin
                r_cursor    <= '0;
                r_missed    <= 1'b0;
                r_ovf       <= 1'b0;
                r_out_valid <= 1'b1;
                r_found     <= w_found;
                r_out_ovf   <= r_ovf;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_overflow  = r_out_ovf;

endmodule

/* test/tb.sv */
// self-checking testbench for the lowercase prefix trie on its stream ports
`timescale 1ns / 100ps

module tb;
    import lpt_pkg::*;

    // op codes beyond the two the package names
    localparam logic [OP_W-1:0] OP_PREFIX     = 2'd2;
    localparam logic [OP_W-1:0] OP_PREFIX_ALT = 2'd3;

    localparam int WORD_MAX       = 16;
    localparam int BANK_SIZE      = 64;
    localparam int PHASE_ITEMS    = 40;
    localparam int STALL_LIMIT    = 5000;

    typedef struct {
        bit found;
        bit overflow;
    } t_trie_answer;

    // trie predictor and answer checker
    class t_trie_scoreboard;
        int unsigned  link_tab [NODE_COUNT_DEF][ALPHABET_SIZE_DEF];
        bit           present [NODE_COUNT_DEF][ALPHABET_SIZE_DEF];
        bit           marked [NODE_COUNT_DEF];
        int unsigned  used;
        int unsigned  cursor;
        bit           missed;
        bit           overflowed;
        t_trie_answer answers_due[$];
        int           errors;

        function new();
            used       = 1;
            cursor     = 0;
            missed     = 0;
            overflowed = 0;
            errors     = 0;
        endfunction

        // walk one letter or close the word on an accepted request
        function void apply_request(logic [OP_W-1:0] op, logic [4:0] letter, logic eow);
            t_trie_answer ans;
            bit walked;
            if (!eow) begin
                if (!(missed || overflowed)) begin
                    if (letter >= ALPHABET_SIZE_DEF) begin
                        missed = 1;
                    end else if (present[cursor][letter]) begin
                        cursor = link_tab[cursor][letter];
                    end else if (op != OP_INSERT) begin
                        missed = 1;
                    end else if (used >= NODE_COUNT_DEF) begin
                        overflowed = 1;
                    end else begin
                        link_tab[cursor][letter] = used;
                        present[cursor][letter]  = 1;
                        cursor = used;
                        used++;
                    end
                end
            end else begin
                walked       = !missed && !overflowed;
                ans.overflow = overflowed;
                if (op == OP_INSERT) begin
                    if (walked) marked[cursor] = 1;
                    ans.found = 0;
                end else if (op == OP_SEARCH) begin
                    ans.found = walked && marked[cursor];
                end else begin
                    ans.found = walked;
                end
                answers_due.push_back(ans);
                cursor     = 0;
                missed     = 0;
                overflowed = 0;
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        // compare one accepted result with the oldest answer due
        task check_answer(logic [7:0] data);
            t_trie_answer want;
            if (answers_due.size() == 0) begin
                report($sformatf("result %h with no request waiting", data));
            end else begin
                want = answers_due.pop_front();
                if (data[0] !== want.found)
                    report($sformatf("found %b, want %b", data[0], want.found));
                if (data[1] !== want.overflow)
                    report($sformatf("overflow %b, want %b", data[1], want.overflow));
                if (data[7:2] !== 6'd0)
                    report($sformatf("fill bits %b not zero", data[7:2]));
            end
        endtask
    endclass

    logic            i_clk      = 1'b0;
    logic            i_rst_n    = 1'b0;
    logic            i_s_tvalid = 1'b0;
    logic            o_s_tready;
    logic [7:0]      i_s_tdata  = 8'd0;   // [4:0] letter, [7:5] zero fill
    logic [OP_W-1:0] i_s_tuser  = '0;     // [1:0] op
    logic            i_s_tlast  = 1'b0;
    logic            o_m_tvalid;
    logic            i_m_tready = 1'b1;
    logic [7:0]      o_m_tdata;           // [0] found, [1] overflow, [7:2] zero fill

    t_trie_scoreboard sb = new();

    int idle_pct  = 0;
    int stall_pct = 0;
    int items_sent;
    int stall_count = 0;

    logic [4:0] wbuf [WORD_MAX];
    logic [4:0] bank [BANK_SIZE][WORD_MAX];
    int         bank_len [BANK_SIZE];
    int         bank_count = 0;
    int         bank_next  = 0;

    lowercase_prefix_trie i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #2 i_clk = ~i_clk;

    // random backpressure on the result side
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99, 0) >= stall_pct);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_answer(o_m_tdata);
    end

    // watchdog on cycles with no request or result moving
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // one request, with random idle cycles ahead of it
    task automatic send_req(input logic [OP_W-1:0] op, input logic [4:0] letter,
                            input logic eow);
        while ($urandom_range(99, 0) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, letter};
        i_s_tuser  <= op;
        i_s_tlast  <= eow;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.apply_request(op, letter, eow);
        items_sent++;
    endtask

    // letters of wbuf then the closing request, with rare per-letter op noise
    task automatic send_word(input logic [OP_W-1:0] op, input int len, input int noise_pct);
        logic [OP_W-1:0] letter_op;
        for (int k = 0; k < len; k++) begin
            letter_op = ($urandom_range(99, 0) < noise_pct) ? OP_W'($urandom_range(3, 0)) : op;
            send_req(letter_op, wbuf[k], 1'b0);
        end
        send_req(op, 5'($urandom_range(31, 0)), 1'b1);
    endtask

    // random word, mostly built from words already inserted
    task automatic random_word();
        int pick;
        int len;
        int slot;
        int pos;
        logic [OP_W-1:0] op;
        pick = $urandom_range(99, 0);
        if (pick < 40) op = OP_INSERT;
        else if (pick < 70) op = OP_SEARCH;
        else if (pick < 94) op = OP_PREFIX;
        else op = OP_PREFIX_ALT;
        if (bank_count > 0 && $urandom_range(99, 0) < 60) begin
            slot = $urandom_range(bank_count - 1, 0);
            len  = bank_len[slot];
            for (int k = 0; k < WORD_MAX; k++) wbuf[k] = bank[slot][k];
            pick = $urandom_range(99, 0);
            if (pick >= 50 && pick < 75 && len > 0) begin
                len = $urandom_range(len - 1, 0);
            end else if (pick >= 75 && pick < 90 && len < WORD_MAX) begin
                wbuf[len] = 5'($urandom_range(ALPHABET_SIZE_DEF - 1, 0));
                len++;
            end else if (pick >= 90 && len > 0) begin
                wbuf[$urandom_range(len - 1, 0)] = 5'($urandom_range(ALPHABET_SIZE_DEF - 1, 0));
            end
        end else begin
            len = $urandom_range(8, 0);
            for (int k = 0; k < len; k++) begin
                // a narrow alphabet half the time so words share prefixes
                wbuf[k] = ($urandom_range(1, 0) == 0) ? 5'($urandom_range(3, 0))
                                                      : 5'($urandom_range(ALPHABET_SIZE_DEF - 1, 0));
            end
        end
        // out of range letter now and then
        if (len > 0 && $urandom_range(99, 0) < 4) begin
            pos = $urandom_range(len - 1, 0);
            wbuf[pos] = 5'($urandom_range(31, ALPHABET_SIZE_DEF));
        end
        if (op == OP_INSERT) begin
            bank_len[bank_next] = len;
            for (int k = 0; k < WORD_MAX; k++) bank[bank_next][k] = wbuf[k];
            bank_next = (bank_next + 1) % BANK_SIZE;
            if (bank_count < BANK_SIZE) bank_count++;
        end
        send_word(op, len, 5);
    endtask

    // hold requests until every answer has come back
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.answers_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty word on the empty trie
        send_req(OP_SEARCH, 5'd7, 1'b1);
        send_req(OP_PREFIX, 5'd31, 1'b1);
        // insert "ab", then query it and its prefix
        send_req(OP_INSERT, 5'd0, 1'b0);
        send_req(OP_INSERT, 5'd1, 1'b0);
        send_req(OP_INSERT, 5'd0, 1'b1);
        send_req(OP_SEARCH, 5'd0, 1'b0);
        send_req(OP_SEARCH, 5'd1, 1'b0);
        send_req(OP_SEARCH, 5'd0, 1'b1);
        send_req(OP_SEARCH, 5'd0, 1'b0);
        send_req(OP_SEARCH, 5'd0, 1'b1);
        send_req(OP_PREFIX, 5'd0, 1'b0);
        send_req(OP_PREFIX, 5'd0, 1'b1);
        // highest letter, queried with the spare op code
        send_req(OP_INSERT, 5'd25, 1'b0);
        send_req(OP_INSERT, 5'd25, 1'b1);
        send_req(OP_PREFIX_ALT, 5'd25, 1'b0);
        send_req(OP_PREFIX_ALT, 5'd3, 1'b1);
        // out of range letter stops an insert without marking
        send_req(OP_INSERT, 5'd0, 1'b0);
        send_req(OP_INSERT, 5'd31, 1'b0);
        send_req(OP_INSERT, 5'd1, 1'b1);
        // missing child halts the walk; later letters are ignored
        send_req(OP_PREFIX, 5'd2, 1'b0);
        send_req(OP_PREFIX, 5'd0, 1'b0);
        send_req(OP_PREFIX, 5'd0, 1'b1);
        // search letter inside an insert word misses, so no mark
        send_req(OP_SEARCH, 5'd16, 1'b0);
        send_req(OP_INSERT, 5'd0, 1'b1);
        // empty insert marks the root
        send_req(OP_INSERT, 5'd0, 1'b1);
        send_req(OP_SEARCH, 5'd0, 1'b1);
        drain();

        // random traffic under each idling mix
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 54; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 12; stall_pct = 12; end
            endcase
            items_sent = 0;
            while (items_sent < PHASE_ITEMS) random_word();
            drain();
        end

        // fill the node pool with one long insert word until it runs out
        idle_pct  = 0;
        stall_pct = 0;
        while (sb.used < NODE_COUNT_DEF) begin
            send_req(OP_INSERT, 5'($urandom_range(ALPHABET_SIZE_DEF - 1, 0)), 1'b0);
        end
        // one more letter finds no free node, then close the word
        send_req(OP_INSERT, 5'($urandom_range(ALPHABET_SIZE_DEF - 1, 0)), 1'b0);
        send_req(OP_INSERT, 5'd0, 1'b1);
        drain();

        // traffic on the full pool: inserts now overflow
        idle_pct  = 12;
        stall_pct = 12;
        items_sent = 0;
        while (items_sent < 50) random_word();
        drain();

        repeat (16) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
